// ===== src/rgpg_pkg.sv =====
`timescale 1ns / 1ps

package rgpg_pkg;

  localparam int COORD_W      = 12;
  localparam int MAX_DIM      = 4096;
  localparam int CURVE_ENTRIES = 256;
  localparam int IDX_W        = $clog2(CURVE_ENTRIES);
  localparam int GRAY_W       = 8;
  localparam int SCALE_W      = 32;
  localparam int SCALE_FRAC   = 20;
  localparam int DIST_FRAC    = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam int D2_W         = 2 * COORD_W + 1;
  localparam int RAD_W        = D2_W + 2 * DIST_FRAC + 1;
  localparam int ROOT_W       = RAD_W / 2;
  localparam int REM_W        = ROOT_W + 3;
  localparam int SQRT_STEPS   = ROOT_W;
  localparam int SQRT_STAGES  = 4;
  localparam int SQRT_SPS     = (SQRT_STEPS + SQRT_STAGES - 1) / SQRT_STAGES;
  localparam int PROD_W       = ROOT_W + SCALE_W;
  localparam int IDX_SHIFT    = SCALE_FRAC + DIST_FRAC;

  localparam logic [COORD_W-1:0] COORD_MAX =
      (MAX_DIM - 1 > (1 << COORD_W) - 1) ? {COORD_W{1'b1}} : COORD_W'(MAX_DIM - 1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd1048576;

  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [IDX_W-1:0]   curve_index;
    logic [GRAY_W-1:0]  curve_value;
  } req_t;

  typedef struct packed {
    logic [GRAY_W-1:0]  gray_level;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
  } rsp_t;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    return (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

endpackage

// ===== src/radial_gradient_pixel_generator.sv =====
`timescale 1ns / 1ps
// Channel  Signals                                   Transaction
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data one register write
// req      req_valid, req_ready, req                 one curve load or one pixel request
// rsp      rsp_valid, rsp_ready, rsp                 one shaded pixel
//
// One transaction is accepted every cycle unless a stall on rsp holds req_ready low.
// A pixel passes delta, a 17-step square root in four stages, scale and the output register.
// Curve loads travel the pipeline too and update the curve in order with pixels.
// Reset clears the center registers and all valid bits and sets the scale to SCALE_RESET;
// the curve is not cleared. A stall on rsp fills empty stages first, so no transaction is lost or repeated.

module radial_gradient_pixel_generator import rgpg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp
);

  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [SCALE_W-1:0] distance_scale;

  logic              d_valid;
  logic              d_ready;
  req_t              d_tag;
  logic [D2_W-1:0]   d_d2;
  logic              q_valid;
  logic              q_ready;
  req_t              q_tag;
  logic [ROOT_W-1:0] q_radius;
  logic              s_valid;
  logic              s_ready;
  req_t              s_tag;
  logic [IDX_W-1:0]  s_index;

  logic [GRAY_W-1:0]  tone_curve [CURVE_ENTRIES];
  logic [GRAY_W-1:0]  gray;
  logic [COORD_W-1:0] ox;
  logic [COORD_W-1:0] oy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= '0;
      origin_y       <= '0;
      distance_scale <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CENTER_X: origin_x       <= cfg_data[COORD_W-1:0];
        CFG_CENTER_Y: origin_y       <= cfg_data[COORD_W-1:0];
        CFG_SCALE:    distance_scale <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rgpg_delta u_delta (
    .clk       (clk),
    .rst       (rst),
    .origin_x  (origin_x),
    .origin_y  (origin_y),
    .in_valid  (req_valid),
    .in_ready  (req_ready),
    .in_item   (req),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_tag   (d_tag),
    .d2        (d_d2)
  );

  rgpg_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_tag    (d_tag),
    .d2        (d_d2),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_tag   (q_tag),
    .radius    (q_radius)
  );

  rgpg_scale u_scale (
    .clk            (clk),
    .rst            (rst),
    .distance_scale (distance_scale),
    .in_valid       (q_valid),
    .in_ready       (q_ready),
    .in_tag         (q_tag),
    .radius         (q_radius),
    .out_valid      (s_valid),
    .out_ready      (s_ready),
    .out_tag        (s_tag),
    .index          (s_index)
  );

  assign s_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s_ready) begin
      rsp_valid <= s_valid && (s_tag.operation == OP_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready) begin
      if (s_valid && (s_tag.operation == OP_LOAD)) begin
        tone_curve[s_tag.curve_index] <= s_tag.curve_value;
      end
      gray <= tone_curve[s_index];
      ox   <= s_tag.pixel_x;
      oy   <= s_tag.pixel_y;
    end
  end

  always_comb begin
    rsp.gray_level = gray;
    rsp.out_x      = ox;
    rsp.out_y      = oy;
  end

endmodule

// ===== src/rgpg_delta.sv =====
`timescale 1ns / 1ps

module rgpg_delta import rgpg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [COORD_W-1:0] origin_x,
  input  logic [COORD_W-1:0] origin_y,
  input  logic               in_valid,
  output logic               in_ready,
  input  req_t               in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output req_t               out_tag,
  output logic [D2_W-1:0]    d2
);

  logic               v1;
  req_t               tag1;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic               adv1;
  logic               adv2;

  logic [COORD_W-1:0]   px;
  logic [COORD_W-1:0]   py;
  logic [COORD_W-1:0]   cx;
  logic [COORD_W-1:0]   cy;
  req_t                 tag_next;
  logic [2*COORD_W-1:0] sq_x;
  logic [2*COORD_W-1:0] sq_y;

  assign adv2     = !out_valid || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_comb begin
    px = clamp_coord(in_item.pixel_x);
    py = clamp_coord(in_item.pixel_y);
    cx = clamp_coord(origin_x);
    cy = clamp_coord(origin_y);
    tag_next = in_item;
    tag_next.pixel_x = px;
    tag_next.pixel_y = py;
  end

  assign sq_x = {{COORD_W{1'b0}}, dx} * {{COORD_W{1'b0}}, dx};
  assign sq_y = {{COORD_W{1'b0}}, dy} * {{COORD_W{1'b0}}, dy};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        out_valid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      tag1 <= tag_next;
      dx   <= (px >= cx) ? px - cx : cx - px;
      dy   <= (py >= cy) ? py - cy : cy - py;
    end
    if (adv2) begin
      out_tag <= tag1;
      d2      <= {1'b0, sq_x} + {1'b0, sq_y};
    end
  end

endmodule

// ===== src/rgpg_sqrt.sv =====
`timescale 1ns / 1ps

module rgpg_sqrt import rgpg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  req_t              in_tag,
  input  logic [D2_W-1:0]   d2,
  output logic              out_valid,
  input  logic              out_ready,
  output req_t              out_tag,
  output logic [ROOT_W-1:0] radius
);

  logic              v     [SQRT_STAGES];
  req_t              tag   [SQRT_STAGES];
  logic [ROOT_W-1:0] root  [SQRT_STAGES];
  logic [REM_W-1:0]  rem   [SQRT_STAGES];
  logic [RAD_W-1:0]  rad   [SQRT_STAGES];
  logic [SQRT_STAGES:0] adv;

  logic              pv    [SQRT_STAGES];
  req_t              ptag  [SQRT_STAGES];
  logic [ROOT_W-1:0] nroot [SQRT_STAGES];
  logic [REM_W-1:0]  nrem  [SQRT_STAGES];
  logic [RAD_W-1:0]  nrad  [SQRT_STAGES];

  always_comb begin
    adv[SQRT_STAGES] = out_ready;
    for (int s = SQRT_STAGES - 1; s >= 0; s--) begin
      adv[s] = !v[s] || adv[s+1];
    end
  end
  assign in_ready = adv[0];

  always_comb begin
    logic [ROOT_W-1:0] r;
    logic [REM_W-1:0]  m;
    logic [RAD_W-1:0]  a;
    logic [REM_W-1:0]  t;
    for (int s = 0; s < SQRT_STAGES; s++) begin
      if (s == 0) begin
        pv[s]   = in_valid;
        ptag[s] = in_tag;
        r = '0;
        m = '0;
        a = RAD_W'({d2, {(2 * DIST_FRAC){1'b0}}});
      end else begin
        pv[s]   = v[s-1];
        ptag[s] = tag[s-1];
        r = root[s-1];
        m = rem[s-1];
        a = rad[s-1];
      end
      for (int k = 0; k < SQRT_SPS; k++) begin
        if (s * SQRT_SPS + k < SQRT_STEPS) begin
          m = {m[REM_W-3:0], a[RAD_W-1 -: 2]};
          a = {a[RAD_W-3:0], 2'b00};
          t = REM_W'({r, 2'b01});
          if (m >= t) begin
            m = m - t;
            r = {r[ROOT_W-2:0], 1'b1};
          end else begin
            r = {r[ROOT_W-2:0], 1'b0};
          end
        end
      end
      nroot[s] = r;
      nrem[s]  = m;
      nrad[s]  = a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
        v[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
        if (adv[s]) begin
          v[s] <= pv[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SQRT_STAGES; s++) begin
      if (adv[s]) begin
        tag[s]  <= ptag[s];
        root[s] <= nroot[s];
        rem[s]  <= nrem[s];
        rad[s]  <= nrad[s];
      end
    end
  end

  assign out_valid = v[SQRT_STAGES-1];
  assign out_tag   = tag[SQRT_STAGES-1];
  assign radius    = root[SQRT_STAGES-1];

endmodule

// ===== src/rgpg_scale.sv =====
`timescale 1ns / 1ps

module rgpg_scale import rgpg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [SCALE_W-1:0] distance_scale,
  input  logic               in_valid,
  output logic               in_ready,
  input  req_t               in_tag,
  input  logic [ROOT_W-1:0]  radius,
  output logic               out_valid,
  input  logic               out_ready,
  output req_t               out_tag,
  output logic [IDX_W-1:0]   index
);

  logic              v1;
  req_t              tag1;
  logic [PROD_W-1:0] prod;
  logic              adv1;
  logic              adv2;
  logic              over;

  assign adv2     = !out_valid || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  assign over = |prod[PROD_W-1:IDX_SHIFT+IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        out_valid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      tag1 <= in_tag;
      prod <= PROD_W'(radius) * PROD_W'(distance_scale);
    end
    if (adv2) begin
      out_tag <= tag1;
      index   <= over ? {IDX_W{1'b1}} : prod[IDX_SHIFT+IDX_W-1:IDX_SHIFT];
    end
  end

endmodule

// ===== tb/sv/tb_radial_gradient_pixel_generator.sv =====
`timescale 1ns / 1ps

module tb_radial_gradient_pixel_generator;
  import rgpg_pkg::*;

  localparam int PIPE_DRAIN = 20;
  localparam int IDLE_PCT = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  req_valid;
  logic                  req_ready;
  req_t                  req;
  logic                  rsp_valid;
  logic                  rsp_ready;
  rsp_t                  rsp;

  logic [GRAY_W-1:0]  curve_copy [CURVE_ENTRIES];
  logic [COORD_W-1:0] origin_x_reg;
  logic [COORD_W-1:0] origin_y_reg;
  logic [SCALE_W-1:0] scale_reg;
  rsp_t               shade_expect [$];
  int                 failures;
  bit                 steady;

  radial_gradient_pixel_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("radial_gradient_pixel_generator regression: fail");
    $finish;
  end

  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic logic [COORD_W-1:0] fit_coord(input logic [COORD_W-1:0] v);
    return (v > MAX_DIM - 1) ? COORD_W'(MAX_DIM - 1) : v;
  endfunction

  function automatic rsp_t shade_pixel(input logic [COORD_W-1:0] px_in,
                                       input logic [COORD_W-1:0] py_in);
    logic [COORD_W-1:0] px, py, cx, cy;
    logic [63:0] dx, dy, rad, root, trial, prod, slot;
    rsp_t r;
    px = fit_coord(px_in);
    py = fit_coord(py_in);
    cx = fit_coord(origin_x_reg);
    cy = fit_coord(origin_y_reg);
    dx = (px >= cx) ? 64'(px - cx) : 64'(cx - px);
    dy = (py >= cy) ? 64'(py - cy) : 64'(cy - py);
    rad = (dx * dx + dy * dy) << (2 * DIST_FRAC);
    root = '0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= rad) root = trial;
    end
    prod = root * 64'(scale_reg);
    slot = prod >> IDX_SHIFT;
    if (slot > CURVE_ENTRIES - 1) slot = CURVE_ENTRIES - 1;
    r.gray_level = curve_copy[slot[IDX_W-1:0]];
    r.out_x = px;
    r.out_y = py;
    return r;
  endfunction

  function automatic req_t pixel_item(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    req_t it;
    it.operation = OP_PIXEL;
    it.pixel_x = x;
    it.pixel_y = y;
    it.curve_index = IDX_W'($urandom);
    it.curve_value = GRAY_W'($urandom);
    return it;
  endfunction

  function automatic req_t load_item(input logic [IDX_W-1:0] idx, input logic [GRAY_W-1:0] val);
    req_t it;
    it.operation = OP_LOAD;
    it.pixel_x = COORD_W'($urandom);
    it.pixel_y = COORD_W'($urandom);
    it.curve_index = idx;
    it.curve_value = val;
    return it;
  endfunction

  function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 600)) - 300;
    if (v < 0) v = 0;
    if (v > MAX_DIM - 1) v = MAX_DIM - 1;
    return COORD_W'(v);
  endfunction

  task automatic note_failure(input string what);
    failures++;
    if (failures <= 10) $display("%0t: %s", $time, what);
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic push_request(input req_t item);
    while (take_gap()) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (item.operation == OP_LOAD) curve_copy[item.curve_index] = item.curve_value;
    else shade_expect.push_back(shade_pixel(item.pixel_x, item.pixel_y));
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    req_valid <= 1'b0;
    while (shade_expect.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CENTER_X: origin_x_reg = data[COORD_W-1:0];
      CFG_CENTER_Y: origin_y_reg = data[COORD_W-1:0];
      CFG_SCALE:    scale_reg = data[SCALE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_center(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    write_register(CFG_CENTER_X, {junk[CFG_DATA_W-1:COORD_W], x});
    junk = $urandom;
    write_register(CFG_CENTER_Y, {junk[CFG_DATA_W-1:COORD_W], y});
  endtask

  task automatic test_load_curve();
    int v;
    for (int i = 0; i < CURVE_ENTRIES; i++) begin
      v = 255 - (i * i) / 255;
      push_request(load_item(IDX_W'(i), GRAY_W'(v)));
    end
  endtask

  task automatic test_default_geometry();
    push_request(pixel_item(12'd0, 12'd0));
    push_request(pixel_item(12'd4095, 12'd4095));
    push_request(pixel_item(12'd15, 12'd0));
    push_request(pixel_item(12'd0, 12'd255));
    push_request(pixel_item(12'd4095, 12'd0));
    push_request(pixel_item(12'd0, 12'd4095));
    push_request(load_item(8'd5, 8'hA5));
    push_request(pixel_item(12'd3, 12'd4));
    push_request(load_item(8'd255, 8'h5A));
    push_request(pixel_item(12'd4000, 12'd4000));
  endtask

  task automatic test_center_extremes();
    set_center(12'd4095, 12'd4095);
    push_request(pixel_item(12'd4095, 12'd4095));
    push_request(pixel_item(12'd0, 12'd0));
    push_request(pixel_item(12'd4095, 12'd4080));
    set_center(12'd2048, 12'd2048);
    push_request(pixel_item(12'd2048, 12'd2048));
    push_request(pixel_item(12'd2100, 12'd1990));
  endtask

  task automatic test_scale_extremes();
    write_register(CFG_SCALE, 32'd0);
    push_request(pixel_item(12'd0, 12'd4095));
    push_request(pixel_item(12'd2050, 12'd2048));
    write_register(CFG_SCALE, 32'hFFFF_FFFF);
    push_request(pixel_item(12'd2048, 12'd2048));
    push_request(pixel_item(12'd2049, 12'd2048));
    write_register(CFG_SCALE, 32'd1);
    push_request(pixel_item(12'd0, 12'd0));
    write_register(CFG_SCALE, 32'h0008_0000);
    push_request(pixel_item(12'd2048, 12'd2100));
    write_register(CFG_UNUSED, $urandom);
    push_request(pixel_item(12'd2000, 12'd2048));
  endtask

  task automatic test_random_traffic();
    logic [COORD_W-1:0] x, y;
    logic [SCALE_W-1:0] s;
    for (int phase = 0; phase < 5; phase++) begin
      steady = (phase == 2);
      set_center(COORD_W'($urandom), COORD_W'($urandom));
      case (phase)
        0:       s = SCALE_RESET;
        2:       s = $urandom_range(0, 32'h0020_0000);
        3:       s = $urandom;
        default: s = $urandom_range(0, 32'h0040_0000);
      endcase
      write_register(CFG_SCALE, s);
      for (int n = 0; n < ((phase == 2) ? 45 : 20); n++) begin
        if ($urandom_range(0, 99) < 15) begin
          push_request(load_item(IDX_W'($urandom), GRAY_W'($urandom)));
        end else if ($urandom_range(0, 99) < 60) begin
          x = near_coord(origin_x_reg);
          y = near_coord(origin_y_reg);
          push_request(pixel_item(x, y));
        end else begin
          push_request(pixel_item(COORD_W'($urandom), COORD_W'($urandom)));
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (shade_expect.size() == 0) begin
        note_failure($sformatf("unexpected result gray=%0d x=%0d y=%0d",
                               rsp.gray_level, rsp.out_x, rsp.out_y));
      end else begin
        want = shade_expect.pop_front();
        if (rsp.gray_level !== want.gray_level || rsp.out_x !== want.out_x ||
            rsp.out_y !== want.out_y) begin
          note_failure($sformatf("mismatch: expected gray=%0d x=%0d y=%0d, got gray=%0d x=%0d y=%0d",
                                 want.gray_level, want.out_x, want.out_y,
                                 rsp.gray_level, rsp.out_x, rsp.out_y));
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_valid = 1'b0;
    req = '0;
    failures = 0;
    steady = 1'b0;
    origin_x_reg = '0;
    origin_y_reg = '0;
    scale_reg = SCALE_RESET;
    for (int i = 0; i < CURVE_ENTRIES; i++) curve_copy[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_load_curve();
    test_default_geometry();
    test_center_extremes();
    test_scale_extremes();
    test_random_traffic();

    req_valid <= 1'b0;
    for (int i = 0; i < 20000 && shade_expect.size() != 0; i++) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
    if (shade_expect.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", shade_expect.size()));
    end
    if (failures == 0) begin
      $display("radial_gradient_pixel_generator regression: pass");
    end else begin
      $display("radial_gradient_pixel_generator regression: fail");
    end
    $finish;
  end

endmodule
